// File: src/psvm_pkg.sv
package psvm_pkg;

    // Command codes of an input word
    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_NOTE = 2'd1,
        CMD_TICK = 2'd2
    } t_cmd;

    // Configuration register indexes
    localparam logic [1:0] CFG_SAMPLE_LENGTH     = 2'd0;
    localparam logic [1:0] CFG_RATE_RATIO        = 2'd1;
    localparam logic [1:0] CFG_LEFT_PHASE_OFFSET = 2'd2;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 18;
    localparam int LEN_REG_W = 16;
    localparam int RATE_W    = 18;
    localparam int OFS_W     = 16;
    localparam int STEP_W    = 24;
    localparam int SUM_W     = 19;
    localparam int GAIN_W    = 17;
    localparam int GX_W      = 18;
    localparam int RATIO_W   = 17;

    localparam logic [LEN_REG_W-1:0] RST_SAMPLE_LENGTH     = 16'd24000;
    localparam logic [RATE_W-1:0]    RST_RATE_RATIO        = 18'd65536;
    localparam logic [OFS_W-1:0]     RST_LEFT_PHASE_OFFSET = 16'd655;

    localparam int ATTACK_LEN = 48;
    localparam int DECAY_LEN  = 96;
    localparam logic [STEP_W-1:0] STEP_MAX = 24'hFFFFFF;
    localparam logic [GAIN_W-1:0] GAIN_ONE = 17'd65536;
    // ceil(2^19 / 3): exact divide by three for values below 2^19
    localparam logic [GX_W-1:0]   RECIP3    = 18'd174763;
    localparam int                RECIP3_SH = 19;
    localparam int                SUM_MAX   = 262143;
    localparam int                SUM_MIN   = -262144;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [14:0]        addr;
        logic signed [15:0] value;
        logic signed [5:0]  note;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qport;

    // Q16 values of 2^(k/12) for the major scale degrees
    function automatic logic [RATIO_W-1:0] degree_ratio(input logic [2:0] deg);
        logic [RATIO_W-1:0] r;
        unique case (deg)
            3'd0:    r = 17'd65536;
            3'd1:    r = 17'd73562;
            3'd2:    r = 17'd82570;
            3'd3:    r = 17'd87480;
            3'd4:    r = 17'd98193;
            3'd5:    r = 17'd110218;
            3'd6:    r = 17'd123715;
            default: r = 17'd65536;
        endcase
        return r;
    endfunction

endpackage

// File: src/polyphonic_sample_voice_mixer_top.sv
// Eight-voice sample playback mixer.
// Input words enter through push/full; each carries a command: load one Q15
// sample word, start a note, or mix one output tick. Only a tick gives a
// result word, read through empty/pop (left sum, right sum, free voice mask).
// Configuration registers (length, rate ratio, left offset) are written
// through i_cfg_we/i_cfg_index/i_cfg_data; the user must write them only
// while the block is idle, which the block itself does not enforce. A
// two-word queue parts the input side from the engine, so push may run
// ahead while a tick is being mixed.
// A tick walks the voices one by one; each busy voice takes a right read
// and, unless it falls past the end, a left read. How long a tick takes is
// set by the single sample memory port, which the engine walks voice by
// voice, and by the shared interpolate/gain multiplier chain that each of
// the up to two reads per voice goes through.
// Reset frees every voice and restores the register defaults; the sample
// memory keeps its contents and must be loaded before it is played.
// When the receiver holds off pop, the finished result word holds on the
// outputs and the engine stalls before posting the next one; input words
// keep queueing until the queue is full.
module polyphonic_sample_voice_mixer_top #(
    parameter int VOICE_COUNT     = 8,
    parameter int SAMPLE_DEPTH    = 32768,
    parameter int PHASE_FRAC_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [1:0]                         i_command,
    input  logic [14:0]                        i_load_address,
    input  logic signed [15:0]                 i_load_value,
    input  logic signed [5:0]                  i_note_offset,
    output logic                               empty,
    input  logic                               pop,
    output logic signed [psvm_pkg::SUM_W-1:0]  o_left_sum,
    output logic signed [psvm_pkg::SUM_W-1:0]  o_right_sum,
    output logic [VOICE_COUNT-1:0]             o_free_mask,
    input  logic                               i_cfg_we,
    input  logic [psvm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [psvm_pkg::CFG_W-1:0]         i_cfg_data
);
    import psvm_pkg::*;

    // configuration registers
    logic [LEN_REG_W-1:0] r_sample_length;
    logic [RATE_W-1:0]    r_rate_ratio;
    logic [OFS_W-1:0]     r_left_phase_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_length     <= RST_SAMPLE_LENGTH;
            r_rate_ratio        <= RST_RATE_RATIO;
            r_left_phase_offset <= RST_LEFT_PHASE_OFFSET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SAMPLE_LENGTH:     r_sample_length     <= i_cfg_data[LEN_REG_W-1:0];
                CFG_RATE_RATIO:        r_rate_ratio        <= i_cfg_data[RATE_W-1:0];
                CFG_LEFT_PHASE_OFFSET: r_left_phase_offset <= i_cfg_data[OFS_W-1:0];
                default: ;  // drop writes to unknown indexes
            endcase
        end
    end

    t_item  in_item;
    t_qport q;
    logic   take;

    assign in_item.cmd   = i_command;
    assign in_item.addr  = i_load_address;
    assign in_item.value = i_load_value;
    assign in_item.note  = i_note_offset;

    // front: accept and classify words into the short queue
    psvm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (in_item),
        .o_full  (full),
        .o_q     (q),
        .i_take  (take)
    );

    // back: sample memory, voice state and mixing engine
    psvm_back #(
        .VOICE_COUNT     (VOICE_COUNT),
        .SAMPLE_DEPTH    (SAMPLE_DEPTH),
        .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
    ) u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_q                 (q),
        .o_take              (take),
        .i_sample_length     (r_sample_length),
        .i_rate_ratio        (r_rate_ratio),
        .i_left_phase_offset (r_left_phase_offset),
        .o_empty             (empty),
        .i_pop               (pop),
        .o_left_sum          (o_left_sum),
        .o_right_sum         (o_right_sum),
        .o_free_mask         (o_free_mask)
    );

endmodule

// File: src/psvm_ram.sv
module psvm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

// File: src/psvm_front.sv
module psvm_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  psvm_pkg::t_item i_item,
    output logic            o_full,
    output psvm_pkg::t_qport o_q,
    input  logic            i_take
);
    import psvm_pkg::*;

    t_item      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push_ok, keep;

    assign o_full  = (r_cnt == 2'd2);
    assign push_ok = i_push && !o_full;
    // drop words with an unknown command right here
    assign keep    = (i_item.cmd == CMD_LOAD) || (i_item.cmd == CMD_NOTE)
                  || (i_item.cmd == CMD_TICK);

    assign o_q.valid = (r_cnt != 2'd0);
    assign o_q.item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok && keep) begin
                r_mem[r_wp] <= i_item;
                r_wp        <= ~r_wp;
            end
            if (i_take && o_q.valid) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'((push_ok && keep) ? 1 : 0) - 2'((i_take && o_q.valid) ? 1 : 0);
        end
    end

endmodule

// File: src/psvm_back.sv
module psvm_back #(
    parameter int VOICE_COUNT     = 8,
    parameter int SAMPLE_DEPTH    = 32768,
    parameter int PHASE_FRAC_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  psvm_pkg::t_qport                   i_q,
    output logic                               o_take,
    input  logic [psvm_pkg::LEN_REG_W-1:0]     i_sample_length,
    input  logic [psvm_pkg::RATE_W-1:0]        i_rate_ratio,
    input  logic [psvm_pkg::OFS_W-1:0]         i_left_phase_offset,
    output logic                               o_empty,
    input  logic                               i_pop,
    output logic signed [psvm_pkg::SUM_W-1:0]  o_left_sum,
    output logic signed [psvm_pkg::SUM_W-1:0]  o_right_sum,
    output logic [VOICE_COUNT-1:0]             o_free_mask
);
    import psvm_pkg::*;

    localparam int PFB    = PHASE_FRAC_BITS;
    localparam int AW     = $clog2(SAMPLE_DEPTH);
    localparam int LEN_W  = AW + 1;
    localparam int CMP_W  = (LEN_W > LEN_REG_W) ? LEN_W : LEN_REG_W;
    localparam int PH_W   = ((LEN_W + PFB > STEP_W) ? LEN_W + PFB : STEP_W) + 1;
    localparam int RT_W   = PH_W + 1;
    localparam int VW     = $clog2(VOICE_COUNT);
    localparam int INT_W  = PFB + 18;
    localparam int P_W    = INT_W + 18;
    localparam int ACC_W  = 20 + VW;
    localparam int SH_BASE = 37 - PFB;

    localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(SUM_MAX);
    localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(SUM_MIN);

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_NOTE0 = 13'b0000000000010,
        S_NOTE1 = 13'b0000000000100,
        S_CHK   = 13'b0000000001000,
        S_RD0   = 13'b0000000010000,
        S_RD1   = 13'b0000000100000,
        S_RD2   = 13'b0000001000000,
        S_RD3   = 13'b0000010000000,
        S_RD4   = 13'b0000100000000,
        S_RD5   = 13'b0001000000000,
        S_ADV   = 13'b0010000000000,
        S_OUT   = 13'b0100000000000,
        S_WAIT  = 13'b1000000000000
    } t_state;

    t_state r_state;

    logic [PH_W-1:0]   r_phase [VOICE_COUNT];
    logic [STEP_W-1:0] r_step  [VOICE_COUNT];
    logic [VOICE_COUNT-1:0] r_free;
    logic [VW-1:0]     r_v;
    logic [RT_W-1:0]   r_rt;
    logic              r_left;
    logic signed [5:0] r_note;
    logic [34:0]       r_prod;
    logic [4:0]        r_sh;
    logic [GX_W-1:0]   r_gx;
    logic              r_gfull;
    logic [GAIN_W-1:0] r_g;
    logic signed [15:0] r_s0;
    logic signed [INT_W-1:0] r_df, r_int;
    logic signed [P_W-1:0]   r_p;
    logic signed [ACC_W-1:0] r_accl, r_accr;
    logic              r_ov;
    logic signed [SUM_W-1:0] r_lsum, r_rsum;
    logic [VOICE_COUNT-1:0]  r_omask;

    // memory port
    logic              ram_we;
    logic [AW-1:0]     ram_addr;
    logic [15:0]       ram_rdata;

    psvm_ram #(.WIDTH(16), .DEPTH(SAMPLE_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_q.item.value),
        .o_rdata (ram_rdata)
    );

    // effective length, end and left offset
    logic [CMP_W-1:0] len_sl, len_dep;
    logic [LEN_W-1:0] len;
    logic [RT_W-1:0]  end_x;
    logic [PFB+15:0]  ofs_tmp;
    logic [RT_W-1:0]  off_x, tl;
    logic [AW-1:0]    idx, nxt;
    logic [LEN_W-1:0] idx1;
    logic [RT_W-1:0]  rem;
    logic [RT_W+11:0] tmp_a;
    logic [RT_W+10:0] tmp_d;
    logic             att, dec;
    logic [CMP_W-1:0] addr_c;
    logic             addr_ok;

    assign len_sl  = CMP_W'(i_sample_length);
    assign len_dep = CMP_W'(SAMPLE_DEPTH);
    assign len     = LEN_W'((len_sl > len_dep) ? len_dep : len_sl);
    assign end_x   = RT_W'({len, {PFB{1'b0}}});
    assign ofs_tmp = {i_left_phase_offset, {PFB{1'b0}}};
    assign off_x   = RT_W'(ofs_tmp[PFB+15:16]);
    assign tl      = RT_W'(r_phase[r_v]) + off_x;
    assign idx     = r_rt[PFB+AW-1:PFB];
    assign idx1    = LEN_W'(idx) + LEN_W'(1);
    assign nxt     = (idx1 < len) ? AW'(idx1) : AW'(0);
    assign rem     = end_x - r_rt;
    assign tmp_a   = {r_rt, 12'b0};
    assign tmp_d   = {rem, 11'b0};
    assign att     = (r_rt <= (RT_W'(ATTACK_LEN) << PFB));
    assign dec     = (rem <= (RT_W'(DECAY_LEN) << PFB));
    assign addr_c  = CMP_W'(i_q.item.addr);
    assign addr_ok = (addr_c < len_dep);

    // note decode: floor split of the offset by 7
    logic [6:0]  u, q7;
    logic [13:0] qm;
    logic [3:0]  q;
    logic [2:0]  deg;
    assign u   = 7'({r_note[5], r_note}) + 7'd35;
    assign qm  = 14'(u) * 14'd37;
    assign q   = qm[11:8];
    assign q7  = 7'(q) * 7'd7;
    assign deg = 3'(u - q7);

    logic [35:0]       rnd, stepw;
    logic [STEP_W-1:0] step_sat;
    logic [VW-1:0]     pick;
    assign rnd      = 36'(r_prod) + (36'(1) << (r_sh - 5'd1));
    assign stepw    = rnd >> r_sh;
    assign step_sat = (stepw > 36'(STEP_MAX)) ? STEP_MAX : STEP_W'(stepw);

    always_comb begin
        pick = VW'(VOICE_COUNT - 1);
        if (r_free != '0) begin
            for (int i = 0; i < VOICE_COUNT; i++) begin
                if (r_free[i]) pick = VW'(i);
            end
        end
    end

    // datapath helpers
    logic signed [16:0]      dsm;
    logic signed [PFB:0]     frac_s;
    logic signed [INT_W-1:0] s0x;
    logic signed [17:0]      gs;
    logic signed [P_W-1:0]   rsum;
    logic signed [ACC_W-1:0] contrib;
    logic [35:0]             gprod;
    logic [PH_W-1:0]         ph_adv;
    logic                    last_v;

    assign dsm     = 17'(signed'(ram_rdata)) - 17'(r_s0);
    assign frac_s  = $signed({1'b0, r_rt[PFB-1:0]});
    assign s0x     = INT_W'(r_s0);
    assign gs      = $signed({1'b0, r_g});
    assign rsum    = r_p + $signed(P_W'(1) << (PFB + 15));
    assign contrib = ACC_W'(rsum >>> (PFB + 16));
    assign gprod   = 36'(r_gx) * 36'(RECIP3);
    assign ph_adv  = r_phase[r_v] + PH_W'(r_step[r_v]);
    assign last_v  = (r_v == VW'(VOICE_COUNT - 1));

    assign o_take = (r_state == S_IDLE) && i_q.valid;

    always_comb begin
        ram_we   = 1'b0;
        ram_addr = idx;
        unique case (r_state)
            S_IDLE: begin
                ram_addr = AW'(i_q.item.addr);
                ram_we   = i_q.valid && (i_q.item.cmd == CMD_LOAD) && addr_ok;
            end
            S_RD1:   ram_addr = nxt;
            default: ram_addr = idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_free  <= '1;
            r_ov    <= 1'b0;
            r_v     <= '0;
            r_left  <= 1'b0;
            for (int i = 0; i < VOICE_COUNT; i++) begin
                r_phase[i] <= '0;
                r_step[i]  <= '0;
            end
        end else begin
            if (i_pop && r_ov && (r_state != S_WAIT)) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_q.valid) begin
                        case (i_q.item.cmd)
                            CMD_NOTE: begin
                                r_note  <= i_q.item.note;
                                r_state <= S_NOTE0;
                            end
                            CMD_TICK: begin
                                r_accl  <= '0;
                                r_accr  <= '0;
                                r_v     <= '0;
                                r_state <= S_CHK;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_NOTE0: begin
                    r_prod  <= 35'(i_rate_ratio) * 35'(degree_ratio(deg));
                    r_sh    <= 5'(SH_BASE) - 5'(q);
                    r_state <= S_NOTE1;
                end
                S_NOTE1: begin
                    r_phase[pick] <= '0;
                    r_step[pick]  <= step_sat;
                    r_free[pick]  <= 1'b0;
                    r_state       <= S_IDLE;
                end
                S_CHK: begin
                    if (!r_free[r_v] && (RT_W'(r_phase[r_v]) < end_x)) begin
                        r_rt    <= RT_W'(r_phase[r_v]);
                        r_left  <= 1'b0;
                        r_state <= S_RD0;
                    end else begin
                        r_free[r_v] <= 1'b1;
                        r_v         <= r_v + VW'(1);
                        r_state     <= last_v ? S_OUT : S_CHK;
                    end
                end
                S_RD0: begin
                    r_gfull <= !att && !dec;
                    r_gx    <= att ? GX_W'(tmp_a >> PFB) : GX_W'(tmp_d >> PFB);
                    r_state <= S_RD1;
                end
                S_RD1: begin
                    r_s0    <= ram_rdata;
                    r_g     <= r_gfull ? GAIN_ONE : GAIN_W'(gprod >> RECIP3_SH);
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    r_df    <= INT_W'(dsm * frac_s);
                    r_state <= S_RD3;
                end
                S_RD3: begin
                    r_int   <= (s0x <<< PFB) + r_df;
                    r_state <= S_RD4;
                end
                S_RD4: begin
                    r_p     <= P_W'(r_int * gs);
                    r_state <= S_RD5;
                end
                S_RD5: begin
                    if (r_left) begin
                        r_accl  <= r_accl + contrib;
                        r_state <= S_ADV;
                    end else begin
                        r_accr <= r_accr + contrib;
                        if (tl < end_x) begin
                            r_rt    <= tl;
                            r_left  <= 1'b1;
                            r_state <= S_RD0;
                        end else begin
                            r_state <= S_ADV;
                        end
                    end
                end
                S_ADV: begin
                    r_phase[r_v] <= ph_adv;
                    if (RT_W'(ph_adv) >= end_x) r_free[r_v] <= 1'b1;
                    r_v     <= r_v + VW'(1);
                    r_state <= last_v ? S_OUT : S_CHK;
                end
                S_OUT: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (!r_ov || i_pop) begin
                        r_ov    <= 1'b1;
                        r_lsum  <= (r_accl > ACC_MAX) ? SUM_W'(ACC_MAX) :
                                   (r_accl < ACC_MIN) ? SUM_W'(ACC_MIN) : SUM_W'(r_accl);
                        r_rsum  <= (r_accr > ACC_MAX) ? SUM_W'(ACC_MAX) :
                                   (r_accr < ACC_MIN) ? SUM_W'(ACC_MIN) : SUM_W'(r_accr);
                        r_omask <= r_free;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_empty     = !r_ov;
    assign o_left_sum  = r_lsum;
    assign o_right_sum = r_rsum;
    assign o_free_mask = r_omask;

endmodule

// File: src/psvm_checker.sv
module psvm_checker #(
    parameter int VOICE_COUNT = 8
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               push,
    input logic                               full,
    input logic                               empty,
    input logic                               pop,
    input logic signed [psvm_pkg::SUM_W-1:0]  o_left_sum,
    input logic signed [psvm_pkg::SUM_W-1:0]  o_right_sum,
    input logic [VOICE_COUNT-1:0]             o_free_mask
);

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not cleared by reset");

    a_full_needs_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !full && !push |=> !full)
        else $error("full rose without a word pushed");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_left_sum) && $stable(o_right_sum)
            && $stable(o_free_mask))
        else $error("result word changed while stalled");

endmodule

bind polyphonic_sample_voice_mixer_top psvm_checker #(.VOICE_COUNT(VOICE_COUNT)) u_chk (.*);

// File: dv/polyphonic_sample_voice_mixer_top_tb.sv
`timescale 1ns / 100ps

module polyphonic_sample_voice_mixer_top_tb;
    import psvm_pkg::*;

    localparam int VOICES = 8;
    localparam int DEPTH  = 32768;
    localparam int FRAC   = 16;

    typedef struct {
        int       left;
        int       right;
        bit [7:0] mask;
    } t_mix_word;

    // Mixer model plus the queue of mix words still owed by the block.
    class t_mix_scoreboard;
        int unsigned        len_reg;
        int unsigned        rate_reg;
        int unsigned        ofs_reg;
        bit [7:0]           idle_voices;
        longint             phase [VOICES];
        longint             step [VOICES];
        logic signed [15:0] pcm [DEPTH];
        bit                 loaded [DEPTH];
        int unsigned        deg_ratio [7] = '{65536, 73562, 82570, 87480, 98193, 110218,
                                              123715};
        t_mix_word          mix_q [$];
        int                 errors;
        int                 checked;

        function void reset_state();
            len_reg     = RST_SAMPLE_LENGTH;
            rate_reg    = RST_RATE_RATIO;
            ofs_reg     = RST_LEFT_PHASE_OFFSET;
            idle_voices = '1;
            foreach (phase[v]) begin
                phase[v] = 0;
                step[v]  = 0;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
            case (idx)
                CFG_SAMPLE_LENGTH:     len_reg  = d[LEN_REG_W-1:0];
                CFG_RATE_RATIO:        rate_reg = d[RATE_W-1:0];
                CFG_LEFT_PHASE_OFFSET: ofs_reg  = d[OFS_W-1:0];
                default: ;
            endcase
        endfunction

        function longint stop_point();
            longint len;
            len = (len_reg > DEPTH) ? DEPTH : len_reg;
            return len << FRAC;
        endfunction

        // Major-scale degree to Q16 step, rounded, saturated to 24 bits.
        function longint note_step(logic signed [5:0] note);
            int     n;
            int     deg;
            int     oct;
            int     sh;
            longint prod;
            longint s;
            n    = note;
            deg  = ((n % 7) + 7) % 7;
            oct  = (n - deg) / 7;
            sh   = 32 - FRAC - oct;
            prod = longint'(rate_reg) * longint'(deg_ratio[deg]);
            s    = (prod + (64'sd1 <<< (sh - 1))) >>> sh;
            return (s > STEP_MAX) ? longint'(STEP_MAX) : s;
        endfunction

        // One interpolated, enveloped read at phase t, Q15 result.
        function longint read_q15(longint t, longint stop_p);
            longint idx;
            longint frac;
            longint nxt;
            longint rem;
            longint g;
            longint interp;
            longint len;
            len  = stop_p >>> FRAC;
            idx  = t >>> FRAC;
            frac = t & ((64'sd1 <<< FRAC) - 1);
            nxt  = (idx + 1 < len) ? idx + 1 : 0;
            rem  = stop_p - t;
            if (t <= (longint'(ATTACK_LEN) <<< FRAC))
                g = (t <<< 16) / (longint'(ATTACK_LEN) <<< FRAC);
            else if (rem <= (longint'(DECAY_LEN) <<< FRAC))
                g = (rem <<< 16) / (longint'(DECAY_LEN) <<< FRAC);
            else
                g = 65536;
            interp = longint'(pcm[idx]) * ((64'sd1 <<< FRAC) - frac)
                   + longint'(pcm[nxt]) * frac;
            return (interp * g + (64'sd1 <<< (FRAC + 15))) >>> (FRAC + 16);
        endfunction

        // Addresses the next tick would read that hold no loaded word yet.
        function void words_needed(output int unsigned need [$]);
            longint stop_p;
            longint t;
            longint idx;
            longint len;
            need   = {};
            stop_p = stop_point();
            len    = stop_p >>> FRAC;
            for (int v = 0; v < VOICES; v++) begin
                if (idle_voices[v] || phase[v] >= stop_p) continue;
                for (int k = 0; k < 2; k++) begin
                    t = phase[v] + (k ? longint'(ofs_reg) : 0);
                    if (t >= stop_p) continue;
                    idx = t >>> FRAC;
                    if (!loaded[idx]) need.push_back(idx);
                    idx = (idx + 1 < len) ? idx + 1 : 0;
                    if (!loaded[idx]) need.push_back(idx);
                end
            end
        endfunction

        function int clip_sum(longint s);
            if (s > SUM_MAX) return SUM_MAX;
            if (s < SUM_MIN) return SUM_MIN;
            return int'(s);
        endfunction

        function void note_word(logic [1:0] cmd, logic [14:0] addr,
                                logic signed [15:0] value, logic signed [5:0] note);
            longint    stop_p;
            longint    t;
            longint    l_acc;
            longint    r_acc;
            int        v;
            t_mix_word w;
            case (cmd)
                CMD_LOAD: begin
                    pcm[addr]    = value;
                    loaded[addr] = 1'b1;
                end
                CMD_NOTE: begin
                    v = VOICES - 1;
                    if (idle_voices != 0)
                        while (!idle_voices[v]) v--;
                    phase[v]       = 0;
                    step[v]        = note_step(note);
                    idle_voices[v] = 1'b0;
                end
                CMD_TICK: begin
                    stop_p = stop_point();
                    l_acc  = 0;
                    r_acc  = 0;
                    for (v = 0; v < VOICES; v++) begin
                        if (idle_voices[v]) continue;
                        t = phase[v];
                        if (t >= stop_p) begin
                            idle_voices[v] = 1'b1;
                            continue;
                        end
                        r_acc += read_q15(t, stop_p);
                        if (t + ofs_reg < stop_p) l_acc += read_q15(t + ofs_reg, stop_p);
                        phase[v] = t + step[v];
                        if (phase[v] >= stop_p) idle_voices[v] = 1'b1;
                    end
                    w.left  = clip_sum(l_acc);
                    w.right = clip_sum(r_acc);
                    w.mask  = idle_voices;
                    mix_q.push_back(w);
                end
                default: ;
            endcase
        endfunction

        function void check_mix(int left, int right, bit [7:0] mask);
            t_mix_word w;
            if (mix_q.size() == 0) begin
                $error("mix word with none expected: left %0d right %0d mask %02h",
                       left, right, mask);
                errors++;
                return;
            end
            w = mix_q.pop_front();
            checked++;
            if (w.left != left) begin
                $error("left_sum: expected %0d, actual %0d", w.left, left);
                errors++;
            end
            if (w.right != right) begin
                $error("right_sum: expected %0d, actual %0d", w.right, right);
                errors++;
            end
            if (w.mask != mask) begin
                $error("free_mask: expected %02h, actual %02h", w.mask, mask);
                errors++;
            end
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     push;
    logic                     full;
    logic [1:0]               i_command;
    logic [14:0]              i_load_address;
    logic signed [15:0]       i_load_value;
    logic signed [5:0]        i_note_offset;
    logic                     empty;
    logic                     pop;
    logic signed [SUM_W-1:0]  o_left_sum;
    logic signed [SUM_W-1:0]  o_right_sum;
    logic [VOICES-1:0]        o_free_mask;
    logic                     i_cfg_we;
    logic [CFG_IDX_W-1:0]     i_cfg_index;
    logic [CFG_W-1:0]         i_cfg_data;

    t_mix_scoreboard sb;

    // Sender burst state and run statistics
    int burst_left;
    int counted_words;
    int n_loads;
    int n_notes;
    int n_ticks;
    int n_ignored;
    int n_cfg;

    // Receiver stall pattern
    int stall_mode;
    int stall_left;
    int hold_cnt;

    polyphonic_sample_voice_mixer_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_command      (i_command),
        .i_load_address (i_load_address),
        .i_load_value   (i_load_value),
        .i_note_offset  (i_note_offset),
        .empty          (empty),
        .pop            (pop),
        .o_left_sum     (o_left_sum),
        .o_right_sum    (o_right_sum),
        .o_free_mask    (o_free_mask),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Hard stop in case the block hangs
    initial begin
        #100000000;
        $display("FAIL");
        $finish;
    end

    // Receiver: switch between stall styles at random times so that
    // pop gaps land on every phase of the engine, including no stall at all.
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(50, 400);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: pop <= 1'b1;
            1: pop <= ~pop;
            2: pop <= ($urandom_range(0, 99) < 35);
            default: begin
                // long holds: keep pop low, raising it once between holds
                if (hold_cnt == 0) begin
                    hold_cnt <= $urandom_range(0, 40);
                    pop      <= 1'b1;
                end else begin
                    hold_cnt <= hold_cnt - 1;
                    pop      <= 1'b0;
                end
            end
        endcase
    end

    // Sample at the falling edge: pop and empty are settled and hold until the
    // rising edge that moves the word.
    always @(negedge i_clk) begin
        if (i_rst_n && pop && !empty)
            sb.check_mix(int'(o_left_sum), int'(o_right_sum), o_free_mask);
    end

    function automatic logic signed [15:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [5:0] pick_note();
        return 6'(int'($urandom_range(0, 55)) - 28);
    endfunction

    // Present one word and hold it until the block takes it. Called and
    // returns at a rising edge.
    task automatic push_word(input logic [1:0] cmd, input logic [14:0] addr,
                             input logic signed [15:0] value,
                             input logic signed [5:0] note);
        bit taken;
        push           <= 1'b1;
        i_command      <= cmd;
        i_load_address <= addr;
        i_load_value   <= value;
        i_note_offset  <= note;
        do begin
            @(negedge i_clk);
            taken = !full;
            @(posedge i_clk);
        end while (!taken);
        sb.note_word(cmd, addr, value, note);
        case (cmd)
            CMD_LOAD: n_loads++;
            CMD_NOTE: n_notes++;
            CMD_TICK: n_ticks++;
            default:  n_ignored++;
        endcase
        if (cmd != 2'd3) counted_words++;
        // end of burst: start a new burst, most times after dropping push for a random gap
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0) begin
                push <= 1'b0;
                repeat ($urandom_range(1, 25)) @(posedge i_clk);
            end
        end
    endtask

    // Load every word the next tick will read, then send the tick itself.
    task automatic send_tick();
        int unsigned need [$];
        sb.words_needed(need);
        while (need.size() != 0) begin
            push_word(CMD_LOAD, 15'(need[0]), pick_value(), pick_note());
            sb.words_needed(need);
        end
        push_word(CMD_TICK, 15'($urandom), 16'($urandom), pick_note());
    endtask

    // Hold off the sender until every owed mix word has come, then let a
    // trailing note or load settle.
    task automatic drain();
        push <= 1'b0;
        while (sb.mix_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_W'(value);
        @(posedge i_clk);
        sb.write_reg(idx, CFG_W'(value));
        n_cfg++;
    endtask

    task automatic cfg_all(input int unsigned len, input int unsigned rate,
                           input int unsigned ofs);
        drain();
        cfg_write(CFG_SAMPLE_LENGTH, len);
        cfg_write(CFG_RATE_RATIO, rate);
        cfg_write(CFG_LEFT_PHASE_OFFSET, ofs);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int unsigned len;
        int unsigned rate;
        int unsigned ofs;
        int          n;
        int          r;
        sb = new();
        sb.reset_state();
        push           = 1'b0;
        pop            = 1'b0;
        i_command      = CMD_LOAD;
        i_load_address = '0;
        i_load_value   = '0;
        i_note_offset  = '0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        i_rst_n        = 1'b0;
        stall_mode     = 0;
        stall_left     = 0;
        hold_cnt       = 0;
        burst_left     = 1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extreme words and addresses, an ignored command, every
        // degree direction, a full voice pool and a stolen top voice.
        cfg_all(64, 65536, 655);
        push_word(CMD_LOAD, 15'h7FFF, 16'sh8000, 6'sd0);
        push_word(CMD_LOAD, 15'h0000, 16'sh7FFF, 6'sd0);
        push_word(2'd3, 15'h7FFF, 16'shFFFF, -6'sd1);
        push_word(CMD_NOTE, '0, '0, 6'sd0);
        push_word(CMD_NOTE, '0, '0, 6'sd27);
        push_word(CMD_NOTE, '0, '0, -6'sd28);
        push_word(CMD_NOTE, '0, '0, -6'sd1);
        push_word(CMD_NOTE, '0, '0, 6'sd6);
        push_word(CMD_NOTE, '0, '0, 6'sd7);
        push_word(CMD_NOTE, '0, '0, -6'sd7);
        push_word(CMD_NOTE, '0, '0, 6'sd13);
        push_word(CMD_NOTE, '0, '0, -6'sd14);
        repeat (4) send_tick();
        // Single-word sample, slowest rate: the lowest note gets a zero step
        // and the left read leads by almost a whole word.
        cfg_all(1, 1, 65535);
        push_word(CMD_NOTE, '0, '0, -6'sd28);
        push_word(CMD_NOTE, '0, '0, 6'sd27);
        repeat (3) send_tick();
        // Zero length frees every busy voice at the next tick
        cfg_all(0, 262143, 0);
        repeat (2) send_tick();
        // Length beyond memory is clipped to the full store
        cfg_all(65535, 262143, 0);
        push_word(CMD_NOTE, '0, '0, 6'sd27);
        repeat (3) send_tick();

        // Random phases, each under a fresh register setting
        while (counted_words < 1350) begin
            case ($urandom_range(0, 9))
                0:       len = 0;
                1:       len = 1;
                2:       len = 32768;
                3:       len = $urandom_range(32769, 65535);
                default: len = $urandom_range(2, 400);
            endcase
            case ($urandom_range(0, 5))
                0:       rate = 1;
                1:       rate = 262143;
                2:       rate = 65536;
                default: rate = $urandom_range(1, 262143);
            endcase
            case ($urandom_range(0, 4))
                0:       ofs = 0;
                1:       ofs = 65535;
                default: ofs = $urandom_range(0, 65535);
            endcase
            cfg_all(len, rate, ofs);
            n = $urandom_range(60, 200);
            for (int i = 0; i < n; i++) begin
                r = $urandom_range(0, 99);
                if (r < 50)
                    send_tick();
                else if (r < 78)
                    push_word(CMD_NOTE, 15'($urandom), 16'($urandom), pick_note());
                else if (r < 93)
                    push_word(CMD_LOAD, 15'($urandom), pick_value(), pick_note());
                else
                    push_word(2'd3, 15'($urandom), 16'($urandom), 6'($urandom));
                // now and then let the mixer run dry mid-phase
                if ($urandom_range(0, 99) == 0 && sb.mix_q.size() != 0) begin
                    push <= 1'b0;
                    while (sb.mix_q.size() != 0) @(posedge i_clk);
                end
            end
        end

        drain();
        $display("Covered %0d loads, %0d notes, %0d ticks, %0d ignored words, %0d register writes.",
                 n_loads, n_notes, n_ticks, n_ignored, n_cfg);
        $display("Compared %0d mix words, %0d field mismatches.", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.mix_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
